>>> rtl/otb_pkg.sv
`timescale 1ns / 1ps

package otb_pkg;

  // Bank size and the most firings one scan item may report.
  localparam int NUM_SLOTS = 8;
  localparam int MAX_OUT   = 8;

  localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W      = $clog2(MAX_OUT + 1);

  // Field widths.
  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 3;
  localparam int TIME_W  = 32;
  localparam int EVENT_W = 8;
  localparam int KIND_W  = 2;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 32;

  // Configuration reset values.
  localparam logic [7:0]        TICK_STEP_RST = 8'd5;
  localparam logic [TIME_W-1:0] MATCH_LEN_RST = 32'd90000;
  localparam logic [7:0]        WAIT_CODE_RST = 8'd255;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 3'd0,
    CMD_ARM    = 3'd1,
    CMD_CANCEL = 3'd2,
    CMD_TICK   = 3'd3,
    CMD_SCAN   = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_FLAG   = 2'd2
  } kind_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_TICK_STEP = 2'd0,
    REG_MATCH_LEN = 2'd1,
    REG_WAIT_CODE = 2'd2
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic scan_step;
    logic emit_step;
    logic result_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_go;
    logic scan_done;
    logic fired_any;
    logic emit_done;
    logic out_free;
    logic stopped;
  } dp_status_t;

  // Saturating add of two time values.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

>>> rtl/otb_controller.sv
`timescale 1ns / 1ps

module otb_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  otb_pkg::dp_status_t    status,
  output otb_pkg::ctrl_cmd_t     cmd
);
  import otb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_EMIT,
    S_RESULT
  } state_t;

  state_t state;

  // Items are taken only between commands.
  assign s_tready = (state == S_IDLE);

  // Commands follow from the state and the datapath status.
  always_comb begin
    cmd.latch       = (state == S_IDLE) && s_tvalid;
    cmd.exec        = (state == S_EXEC);
    cmd.scan_step   = (state == S_SCAN);
    cmd.emit_step   = (state == S_EMIT);
    cmd.result_load = (state == S_RESULT) && status.out_free;
  end

  // Sequencing of one item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= status.scan_go ? S_SCAN : S_RESULT;
        end
        S_SCAN: begin
          if (status.scan_done) state <= status.fired_any ? S_EMIT : S_RESULT;
        end
        S_EMIT: begin
          if (status.emit_done) state <= S_IDLE;
        end
        S_RESULT: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/otb_datapath.sv
`timescale 1ns / 1ps

module otb_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [otb_pkg::CFG_A_W-1:0]     cfg_addr,
  input  logic [otb_pkg::CFG_D_W-1:0]     cfg_wdata,
  input  logic [otb_pkg::CMD_W-1:0]       in_command,
  input  logic [otb_pkg::SLOT_W-1:0]      in_slot,
  input  logic [otb_pkg::TIME_W-1:0]      in_delay,
  input  logic [otb_pkg::EVENT_W-1:0]     in_event,
  input  logic                            in_set_waiting,
  input  otb_pkg::ctrl_cmd_t              cmd,
  output otb_pkg::dp_status_t             status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output otb_pkg::kind_t                  out_kind,
  output logic [otb_pkg::SLOT_W-1:0]      out_slot,
  output logic [otb_pkg::EVENT_W-1:0]     out_flag,
  output logic [otb_pkg::TIME_W-1:0]      out_time,
  output logic                            out_over,
  output logic                            out_last
);
  import otb_pkg::*;

  // Configuration registers.
  logic [7:0]        tick_step;
  logic [TIME_W-1:0] match_length;
  logic [7:0]        waiting_code;

  // Latched item.
  cmd_t               item_cmd;
  logic [SLOT_W-1:0]  item_slot;
  logic [TIME_W-1:0]  item_delay;
  logic [EVENT_W-1:0] item_event;
  logic               item_setw;

  // Timer state.
  logic [TIME_W-1:0]  match_time;
  logic               counting;
  logic               stopped;
  logic               ignored;
  logic [NUM_SLOTS-1:0] slot_active;
  logic [TIME_W-1:0]  slot_deadline [NUM_SLOTS];
  logic [EVENT_W-1:0] slot_event    [NUM_SLOTS];
  logic [EVENT_W-1:0] action_flag   [NUM_SLOTS];

  // Scan and emit walk.
  logic [SLOT_IDX_W-1:0] scan_idx;
  logic [CNT_W-1:0]      fire_cnt;
  logic [NUM_SLOTS-1:0]  fire_mask;

  logic [SLOT_IDX_W-1:0] sidx;
  logic                  slot_ok;
  logic                  frozen_pre;
  logic [TIME_W-1:0]     time_after;
  logic                  scan_hit;
  logic                  scan_last;
  logic                  emit_hit;
  logic [NUM_SLOTS-1:0]  mask_rest;
  logic                  emit_last;
  logic                  out_free;
  logic                  emit_load;

  assign sidx    = SLOT_IDX_W'(item_slot);
  assign slot_ok = (32'(item_slot) < 32'(NUM_SLOTS));

  // Frozen test at the start of an item and the time it leaves behind.
  assign frozen_pre = stopped || (match_time >= match_length);
  assign time_after = (item_cmd == CMD_TICK && counting)
                    ? sat_add(match_time, 32'(tick_step)) : match_time;

  // One slot compared per scan step.
  assign scan_hit  = slot_active[scan_idx] && (match_time >= slot_deadline[scan_idx])
                  && (fire_cnt < CNT_W'(MAX_OUT));
  assign scan_last = (scan_idx == SLOT_IDX_W'(NUM_SLOTS - 1));

  // Emit walk: the last firing is the one with no marked slot after it.
  always_comb begin
    mask_rest           = fire_mask;
    mask_rest[scan_idx] = 1'b0;
  end
  assign emit_hit  = fire_mask[scan_idx];
  assign emit_last = (mask_rest == '0);
  assign out_free  = !out_valid || out_ready;
  assign emit_load = cmd.emit_step && emit_hit && out_free;

  always_comb begin
    status.scan_go   = !frozen_pre && (item_cmd == CMD_SCAN);
    status.scan_done = scan_last;
    status.fired_any = (fire_mask != '0) || scan_hit;
    status.emit_done = emit_hit && out_free && emit_last;
    status.out_free  = out_free;
    status.stopped   = stopped;
  end

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step    <= TICK_STEP_RST;
      match_length <= MATCH_LEN_RST;
      waiting_code <= WAIT_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TICK_STEP: tick_step    <= cfg_wdata[7:0];
        REG_MATCH_LEN: match_length <= cfg_wdata[TIME_W-1:0];
        REG_WAIT_CODE: waiting_code <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_cmd   <= cmd_t'(in_command);
      item_slot  <= in_slot;
      item_delay <= in_delay;
      item_event <= in_event;
      item_setw  <= in_set_waiting;
    end
  end

  // Match time, counting and freeze.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_time <= '0;
      counting   <= 1'b0;
      stopped    <= 1'b0;
      ignored    <= 1'b0;
    end else if (cmd.exec) begin
      if (frozen_pre) begin
        stopped <= 1'b1;
        ignored <= 1'b1;
      end else begin
        ignored    <= 1'b0;
        match_time <= time_after;
        stopped    <= (time_after >= match_length);
        if (item_cmd == CMD_START) counting <= 1'b1;
      end
    end
  end

  // Slot activity and action flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) action_flag[i] <= '0;
    end else if (cmd.exec && !frozen_pre && slot_ok) begin
      if (item_cmd == CMD_ARM) begin
        slot_active[sidx] <= 1'b1;
        if (item_setw) action_flag[sidx] <= waiting_code;
      end else if (item_cmd == CMD_CANCEL) begin
        slot_active[sidx] <= 1'b0;
      end
    end else if (cmd.scan_step && scan_hit) begin
      slot_active[scan_idx] <= 1'b0;
      action_flag[scan_idx] <= slot_event[scan_idx];
    end
  end

  // Deadline and event store, written by arm only.
  always_ff @(posedge clk) begin
    if (cmd.exec && !frozen_pre && slot_ok && item_cmd == CMD_ARM) begin
      slot_deadline[sidx] <= sat_add(match_time, item_delay);
      slot_event[sidx]    <= item_event;
    end
  end

  // Scan index, firing count and firing mask.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      scan_idx  <= '0;
      fire_cnt  <= '0;
      fire_mask <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_last ? '0 : scan_idx + 1'b1;
      if (scan_hit) begin
        fire_mask[scan_idx] <= 1'b1;
        fire_cnt            <= fire_cnt + 1'b1;
      end
    end else if (cmd.emit_step && (!emit_hit || out_free)) begin
      scan_idx            <= scan_last ? '0 : scan_idx + 1'b1;
      fire_mask[scan_idx] <= 1'b0;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load || emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_kind <= KIND_FIRED;
      out_slot <= SLOT_W'(scan_idx);
      out_flag <= slot_event[scan_idx];
      out_time <= match_time;
      out_over <= stopped;
      out_last <= emit_last;
    end else if (cmd.result_load) begin
      out_time <= match_time;
      out_over <= stopped;
      out_last <= 1'b1;
      if (!ignored && item_cmd == CMD_READ) begin
        out_kind <= KIND_FLAG;
        out_slot <= item_slot;
        out_flag <= slot_ok ? action_flag[sidx] : '0;
      end else begin
        out_kind <= KIND_STATUS;
        out_slot <= '0;
        out_flag <= '0;
      end
    end
  end

endmodule

>>> rtl/one_shot_event_timer_bank.sv
`timescale 1ns / 1ps
// Bank of one-shot timers sharing one match-time counter.
// Input channel s_*: one item is one command (start, arm, cancel, tick, scan,
// read flag), taken when s_tvalid and s_tready are both high.
// Output channel m_*: each item gives one result, or for a scan one result per
// timer that fired (at most eight), in rising slot order; m_tlast marks the final
// result of an item and m_tuser carries its kind.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_addr (0 tick
// step, 1 match length, 2 waiting code), to be used only while the block is idle.
// Sequencing: an item is taken, executed in the next cycle, and its result is
// loaded once the output register is free. A scan walks the slots one per cycle
// through a single deadline comparator and, if any fired, walks them again up to
// the last firing to emit them.
// One output register sits on the result side; the next item is taken while a
// result still waits, but a stalled receiver holds the block at its next load.
// Reset clears the match time, the counting and frozen state, every slot's active
// bit and action flag, and restores the register defaults. Once the match time
// reaches the match length, every command gives one status result with
// match_over set.

module one_shot_event_timer_bank (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[2:0], slot[5:3], delay_ms[37:6], event_code[45:38], set_waiting[46]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_slot[2:0], flag_value[10:3], match_time_ms[42:11], match_over[43]
  output logic [47:0] m_tdata,
  // kind[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);
  import otb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  kind_t              out_kind;
  logic [SLOT_W-1:0]  out_slot;
  logic [EVENT_W-1:0] out_flag;
  logic [TIME_W-1:0]  out_time;
  logic               out_over;

  otb_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  otb_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_command     (s_tdata[2:0]),
    .in_slot        (s_tdata[5:3]),
    .in_delay       (s_tdata[37:6]),
    .in_event       (s_tdata[45:38]),
    .in_set_waiting (s_tdata[46]),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_kind       (out_kind),
    .out_slot       (out_slot),
    .out_flag       (out_flag),
    .out_time       (out_time),
    .out_over       (out_over),
    .out_last       (m_tlast)
  );

  // Result packing.
  assign m_tdata = {4'b0000, out_over, out_time, out_flag, out_slot};
  assign m_tuser = out_kind;

`ifndef SYNTH
  // Once frozen, the block stays frozen until reset.
  a_frozen_holds: assert property (@(posedge clk) disable iff (rst)
    status.stopped |=> status.stopped)
    else $error("frozen state cleared without reset");

  // An accepted item closes the input until its work is done.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input reopened right after an accepted item");

  // Only a scan gives more than one result, so a non-final result is a firing.
  a_multi_is_fired: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == KIND_FIRED))
    else $error("non-final result that is not a timer firing");
`endif

endmodule
